[design/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the sample frame deframer modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic       OP_DATA  = 1'b0;
  localparam logic       OP_FLUSH = 1'b1;

  localparam logic       KIND_SAMPLE    = 1'b0;
  localparam logic       KIND_FRAME_END = 1'b1;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [23:0] SEP_WORD  = 24'h7FFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } sfd_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] sample;
    logic [15:0]        error_word;
    logic [7:0]         check_xor;
    logic [15:0]        frame_samples;
  } sfd_out_t;

endpackage

[design/sfd_skid.sv]
// ----------------------------------------------------------------------------
// sfd_skid
// Two-entry output skid buffer; upstream ready comes straight from a flop.
// ----------------------------------------------------------------------------
module sfd_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  sfd_pkg::sfd_out_t up_item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output sfd_pkg::sfd_out_t dn_item
);
  import sfd_pkg::*;

  logic     main_valid;
  logic     skid_valid;
  sfd_out_t main_item;
  sfd_out_t skid_item;

  assign up_ready = !skid_valid;
  assign dn_valid = main_valid;
  assign dn_item  = main_item;

  always_ff @(posedge clk) begin
    if (main_valid && !dn_ready) begin
      if (up_valid && !skid_valid) begin
        skid_item <= up_item;
      end
    end else begin
      if (skid_valid) begin
        main_item <= skid_item;
      end else if (up_valid) begin
        main_item <= up_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_valid && !dn_ready) begin
      if (up_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end else begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= up_valid;
      end
    end
  end

endmodule

[design/sample_frame_deframer.sv]
// ----------------------------------------------------------------------------
// sample_frame_deframer
// Groups a byte stream into 3-byte words, emits samples and frame-end items.
// ----------------------------------------------------------------------------
// One input item is taken every cycle while the skid buffer has room. Each byte
// is held in an input register and decoded against the frame state
// combinationally; its result (if any) is registered into a two-entry output
// skid buffer. Input stalls only while the skid buffer holds two results.
// Input ready depends only on flops. A flush item clears the partial frame and
// gives no result.
module sample_frame_deframer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfd_pkg::sfd_in_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::sfd_out_t out_item
);
  import sfd_pkg::*;

  logic        in_v;
  sfd_in_t     in_r;
  logic        skid_ready;
  logic        fire;

  logic [1:0]  byte_phase, byte_phase_next;
  logic        in_trailer, in_trailer_next;
  logic [15:0] partial_word, partial_word_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [15:0] sample_count, sample_count_next;

  logic        res_hit;
  sfd_out_t    res;
  logic [7:0]  xor_byte;
  logic [23:0] word;

  assign fire     = in_v && skid_ready;
  assign in_ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_ready) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_item;
    end
  end

  assign xor_byte = running_xor ^ in_r.data_byte;
  assign word     = {partial_word, in_r.data_byte};

  always_comb begin
    byte_phase_next   = byte_phase;
    in_trailer_next   = in_trailer;
    partial_word_next = partial_word;
    running_xor_next  = running_xor;
    sample_count_next = sample_count;
    res_hit           = 1'b0;
    res               = '0;
    if (in_r.op == OP_FLUSH) begin
      byte_phase_next   = PH_FIRST;
      in_trailer_next   = 1'b0;
      partial_word_next = '0;
      running_xor_next  = '0;
      sample_count_next = '0;
    end else begin
      running_xor_next = xor_byte;
      case (byte_phase)
        PH_FIRST: begin
          partial_word_next = {8'h00, in_r.data_byte};
          byte_phase_next   = PH_SECOND;
        end
        PH_SECOND: begin
          partial_word_next = {partial_word[7:0], in_r.data_byte};
          byte_phase_next   = PH_THIRD;
        end
        default: begin
          byte_phase_next = PH_FIRST;
          if (in_trailer) begin
            res_hit           = 1'b1;
            res.kind          = KIND_FRAME_END;
            res.error_word    = partial_word;
            res.check_xor     = xor_byte;
            res.frame_samples = sample_count;
            in_trailer_next   = 1'b0;
            partial_word_next = '0;
            running_xor_next  = '0;
            sample_count_next = '0;
          end else begin
            partial_word_next = '0;
            if (word == SEP_WORD) begin
              in_trailer_next = 1'b1;
            end else begin
              res_hit    = 1'b1;
              res.kind   = KIND_SAMPLE;
              res.sample = word;
              if (sample_count != COUNT_MAX) begin
                sample_count_next = sample_count + 16'd1;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= PH_FIRST;
      in_trailer   <= 1'b0;
      partial_word <= '0;
      running_xor  <= '0;
      sample_count <= '0;
    end else if (fire) begin
      byte_phase   <= byte_phase_next;
      in_trailer   <= in_trailer_next;
      partial_word <= partial_word_next;
      running_xor  <= running_xor_next;
      sample_count <= sample_count_next;
    end
  end

  sfd_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fire && res_hit),
    .up_ready (skid_ready),
    .up_item  (res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_item  (out_item)
  );

endmodule

[tb/tb_sample_frame_deframer.sv]
// ----------------------------------------------------------------------------
// tb_sample_frame_deframer
// Self-checking bench for the byte stream deframer. A clocked driver offers
// bytes and flushes from a queue, a bit-accurate frame tracker predicts the
// sample and frame-end items, and a clocked monitor checks every item out.
// ----------------------------------------------------------------------------
module tb_sample_frame_deframer;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 400;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sfd_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sfd_out_t out_item;

  sfd_in_t  byte_q[$];
  sfd_out_t deframed_q[$];
  sfd_out_t want_item;

  int send_idle_pct = 25;
  int recv_idle_pct = 67;
  int gen_count     = 0;
  int bytes_taken   = 0;
  int samples_seen  = 0;
  int frames_seen   = 0;
  int mismatch_count = 0;
  int cycle_count   = 0;
  int hold_cnt      = 0;
  bit hold_done     = 1'b0;
  logic [7:0] gen_xor = '0;

  // frame tracker state
  logic [1:0]  fr_phase   = PH_FIRST;
  logic        fr_trailer = 1'b0;
  logic [15:0] fr_partial = '0;
  logic [7:0]  fr_xor     = '0;
  logic [15:0] fr_count   = '0;

  sample_frame_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_frame();
    fr_phase   = PH_FIRST;
    fr_trailer = 1'b0;
    fr_partial = '0;
    fr_xor     = '0;
    fr_count   = '0;
  endtask

  task automatic deframe_byte(input sfd_in_t it);
    sfd_out_t    r;
    logic [23:0] word;
    r = '0;
    if (it.op == OP_FLUSH) begin
      clear_frame();
    end else begin
      fr_xor = fr_xor ^ it.data_byte;
      case (fr_phase)
        PH_FIRST: begin
          fr_partial = {8'h00, it.data_byte};
          fr_phase   = PH_SECOND;
        end
        PH_SECOND: begin
          fr_partial = {fr_partial[7:0], it.data_byte};
          fr_phase   = PH_THIRD;
        end
        default: begin
          fr_phase = PH_FIRST;
          if (fr_trailer) begin
            r.kind          = KIND_FRAME_END;
            r.error_word    = fr_partial;
            r.check_xor     = fr_xor;
            r.frame_samples = fr_count;
            deframed_q.push_back(r);
            clear_frame();
          end else begin
            word       = {fr_partial, it.data_byte};
            fr_partial = '0;
            if (word == SEP_WORD) begin
              fr_trailer = 1'b1;
            end else begin
              if (fr_count != COUNT_MAX) fr_count = fr_count + 16'd1;
              r.kind   = KIND_SAMPLE;
              r.sample = word;
              deframed_q.push_back(r);
            end
          end
        end
      endcase
    end
  endtask

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", msg);
  endtask

  // stimulus building
  task automatic push_byte(input logic [7:0] b);
    sfd_in_t it;
    it.op        = OP_DATA;
    it.data_byte = b;
    byte_q.push_back(it);
    gen_xor = gen_xor ^ b;
    gen_count++;
  endtask

  task automatic push_flush();
    sfd_in_t it;
    it.op        = OP_FLUSH;
    it.data_byte = 8'($urandom);
    byte_q.push_back(it);
    gen_xor = '0;
    gen_count++;
  endtask

  task automatic push_word(input logic [23:0] w);
    push_byte(w[23:16]);
    push_byte(w[15:8]);
    push_byte(w[7:0]);
  endtask

  task automatic close_frame(input logic [15:0] err, input bit intact);
    push_word(SEP_WORD);
    push_byte(err[15:8]);
    push_byte(err[7:0]);
    push_byte(intact ? gen_xor : 8'($urandom));
    gen_xor = '0;
  endtask

  function automatic logic [23:0] pick_sample();
    logic [23:0] w;
    case ($urandom_range(9))
      0: w = 24'h800000;
      1: w = 24'h7FFFFE;
      2: w = 24'h000000;
      3: w = 24'hFFFFFF;
      4: w = 24'h000001;
      default: begin
        w = 24'($urandom);
        if (w == SEP_WORD) w = 24'h123456;
      end
    endcase
    return w;
  endfunction

  function automatic logic [15:0] pick_error();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_stream(input int goal);
    int n;
    int k;
    int pick;
    while (gen_count < goal) begin
      pick = $urandom_range(99);
      n = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(4);
      if (pick < 70) begin
        repeat (n) push_word(pick_sample());
        close_frame(pick_error(), $urandom_range(9) != 0);
      end else if (pick < 80) begin
        repeat (n) push_word(pick_sample());
        if ($urandom_range(1)) push_word(SEP_WORD);
        k = $urandom_range(2);
        repeat (k) push_byte(8'($urandom));
        push_flush();
      end else if (pick < 92) begin
        k = $urandom_range(1, 8);
        repeat (k) begin
          case ($urandom_range(3))
            0: push_byte(8'h7F);
            1: push_byte(8'hFF);
            default: push_byte(8'($urandom));
          endcase
        end
        if ($urandom_range(1)) push_flush();
      end else begin
        push_flush();
      end
    end
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid || deframed_q.size() != 0) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_item);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the output buffer fills and input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          flag_error($sformatf("unexpected item kind %0d sample %h err %h xor %h cnt %0d",
                               out_item.kind, out_item.sample, out_item.error_word,
                               out_item.check_xor, out_item.frame_samples));
        end else begin
          want_item = deframed_q.pop_front();
          if (out_item.kind !== want_item.kind || out_item.sample !== want_item.sample ||
              out_item.error_word !== want_item.error_word ||
              out_item.check_xor !== want_item.check_xor ||
              out_item.frame_samples !== want_item.frame_samples) begin
            flag_error($sformatf({"got kind %0d sample %h err %h xor %h cnt %0d, ",
                                  "want kind %0d sample %h err %h xor %h cnt %0d"},
                                 out_item.kind, out_item.sample, out_item.error_word,
                                 out_item.check_xor, out_item.frame_samples,
                                 want_item.kind, want_item.sample, want_item.error_word,
                                 want_item.check_xor, want_item.frame_samples));
          end
          if (want_item.kind == KIND_FRAME_END) frames_seen++;
          else samples_seen++;
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    // directed: extreme samples, intact frame, empty frame, unaligned
    // separator, flush of a partial word
    push_word(24'h800000);
    push_word(24'h7FFFFE);
    close_frame(16'h1234, 1'b1);
    close_frame(16'hFFFF, 1'b1);
    push_byte(8'h00);
    push_word(SEP_WORD);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h7F);
    push_flush();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    random_stream(700);
    drain();
    send_idle_pct = 67;
    recv_idle_pct = 25;
    random_stream(1400);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_stream(2000);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d input items: flushes, broken and unaligned frames, stalls",
             bytes_taken);
    $display("checked %0d samples and %0d frame ends, empty frames included",
             samples_seen, frames_seen);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/sfd_pkg.sv
design/sfd_skid.sv
design/sample_frame_deframer.sv
tb/tb_sample_frame_deframer.sv
